### hw/rtl/pfla_pkg.sv
// Package for the priority FIFO lock arbiter: sizes, status codes and the
// ring slot increment. It depends on nothing else.
package pfla_pkg;

  localparam int unsigned MAX_LEVELS = 8;
  localparam int unsigned RING_SLOTS = 64;
  localparam int unsigned LVL_W      = 3;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned STATUS_W   = 3;

  localparam logic [CNT_W-1:0]  LEVELS_RESET = CNT_W'(MAX_LEVELS);
  localparam logic [SLOT_W-1:0] SLOT_LAST    = SLOT_W'(RING_SLOTS - 1);

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_REJECTED = 3'd2,
    ST_HANDED   = 3'd3,
    ST_FREE     = 3'd4
  } status_e;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LVL_W-1:0]  level_t;

  // Next slot of a ring, wrapping after the last slot.
  function automatic slot_t ring_next(input slot_t s);
    ring_next = (s == SLOT_LAST) ? '0 : s + slot_t'(1);
  endfunction

endpackage

### hw/rtl/priority_fifo_lock_arbiter.sv
// Top level of the priority FIFO lock arbiter: sequencer, ring pointers and
// one shared increment/compare unit. Depends on pfla_pkg.
//
// A lock on one shared resource with strict priority between levels (level
// zero most urgent) and first-in first-out order inside each level. A request
// is taken at a rising edge with start high and busy low. A lock request
// passes through the accept cycle and one evaluation state; its result is
// on the result ports, marked by result_strobe_o, during the cycle after
// that, and busy is already low then, so a new request can be accepted in
// that same cycle. A release scans the levels one per cycle through the
// shared compare unit, up to and including the first nonempty one (at most the
// number of levels in use). The result strobe lasts exactly one cycle and
// cannot be held off by the receiver. Each level's ring keeps one slot
// unused, so it holds at most RING_SLOTS-1 tickets. The level count register
// is written over its own valid/ready channel, which is always ready; it
// should only be written while busy is low. No clearing pass is needed after
// reset.
module priority_fifo_lock_arbiter
  import pfla_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                opcode_i,
  input  logic [LVL_W-1:0]    request_priority_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CNT_W-1:0]    cfg_wdata_i,
  output logic                result_strobe_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [LVL_W-1:0]    ticket_priority_o,
  output logic [SLOT_W-1:0]   ticket_slot_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic             op_q;
  level_t           idx_q, idx_d;
  logic [CNT_W-1:0] levels_q;
  logic             res_busy_q, res_busy_d;
  slot_t            head_q [MAX_LEVELS];
  slot_t            tail_q [MAX_LEVELS];

  logic             strobe_q, strobe_d;
  status_e          status_q, status_d;
  level_t           tprio_q, tprio_d;
  slot_t            tslot_q, tslot_d;

  logic             accept;
  logic [CNT_W-1:0] n_eff;
  slot_t            cur_head, cur_tail;
  slot_t            inc_in, inc_out, cmp_a;
  logic             cmp_eq;
  logic             head_we, tail_we;
  logic             prio_out_of_range, last_level;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Saturate the programmed count into 1..MAX_LEVELS.
  always_comb begin
    if (levels_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (levels_q > CNT_W'(MAX_LEVELS)) begin
      n_eff = CNT_W'(MAX_LEVELS);
    end else begin
      n_eff = levels_q;
    end
  end

  // The shared unit: one ring increment and one slot compare. A request
  // advances the tail and checks it against the head (ring full); a release
  // checks head against tail (ring empty) and advances the head.
  assign cur_head = head_q[idx_q];
  assign cur_tail = tail_q[idx_q];
  assign inc_in   = (op_q == OP_RELEASE) ? cur_head : cur_tail;
  assign inc_out  = ring_next(inc_in);
  assign cmp_a    = (op_q == OP_RELEASE) ? cur_tail : inc_out;
  assign cmp_eq   = (cmp_a == cur_head);

  assign prio_out_of_range = {1'b0, idx_q} >= n_eff;
  assign last_level        = ({1'b0, idx_q} + CNT_W'(1)) >= n_eff;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    res_busy_d = res_busy_q;
    strobe_d   = 1'b0;
    status_d   = status_q;
    tprio_d    = tprio_q;
    tslot_d    = tslot_q;
    head_we    = 1'b0;
    tail_we    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EVAL;
          idx_d   = (opcode_i == OP_RELEASE) ? '0 : request_priority_i;
        end
      end
      S_EVAL: begin
        if (op_q == OP_REQUEST) begin
          state_d  = S_IDLE;
          strobe_d = 1'b1;
          tprio_d  = '0;
          tslot_d  = '0;
          if (!res_busy_q) begin
            res_busy_d = 1'b1;
            status_d   = ST_GRANTED;
          end else if (prio_out_of_range || cmp_eq) begin
            status_d = ST_REJECTED;
          end else begin
            tail_we  = 1'b1;
            status_d = ST_QUEUED;
            tprio_d  = idx_q;
            tslot_d  = cur_tail;
          end
        end else begin
          if (!cmp_eq) begin
            // Oldest ticket of the most urgent nonempty level wins.
            state_d    = S_IDLE;
            strobe_d   = 1'b1;
            head_we    = 1'b1;
            res_busy_d = 1'b1;
            status_d   = ST_HANDED;
            tprio_d    = idx_q;
            tslot_d    = cur_head;
          end else if (last_level) begin
            state_d    = S_IDLE;
            strobe_d   = 1'b1;
            res_busy_d = 1'b0;
            status_d   = ST_FREE;
            tprio_d    = '0;
            tslot_d    = '0;
          end else begin
            idx_d = idx_q + level_t'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      op_q       <= OP_REQUEST;
      levels_q   <= LEVELS_RESET;
      res_busy_q <= 1'b0;
      strobe_q   <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      res_busy_q <= res_busy_d;
      strobe_q   <= strobe_d;
      if (accept) begin
        op_q <= opcode_i;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        levels_q <= cfg_wdata_i;
      end
      if (head_we) begin
        head_q[idx_q] <= inc_out;
      end
      if (tail_we) begin
        tail_q[idx_q] <= inc_out;
      end
    end
  end

  // Result payload holds between strobes and needs no reset.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    tprio_q  <= tprio_d;
    tslot_q  <= tslot_d;
  end

  assign result_strobe_o   = strobe_q;
  assign status_o          = status_q;
  assign ticket_priority_o = tprio_q;
  assign ticket_slot_o     = tslot_q;

`ifndef ASSERT_OFF
  a_strobe_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == S_EVAL))
    else $error("result strobe without an evaluation cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !result_strobe_o)
    else $error("accepted request did not occupy the sequencer");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && op_q == OP_RELEASE) |-> ({1'b0, idx_q} < n_eff))
    else $error("release scan went past the levels in use");

  a_handed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && (status_o == ST_HANDED || status_o == ST_GRANTED))
      |-> res_busy_q)
    else $error("resource not marked busy after a grant");

  a_free_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && status_o == ST_FREE) |-> !res_busy_q)
    else $error("resource still marked busy after it was freed");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the priority FIFO lock arbiter.
// Depends on pfla_pkg and priority_fifo_lock_arbiter; it needs no other file.
`timescale 1ns / 100ps

module tb;
  import pfla_pkg::*;

  // Timing of the run. A release scans at most MAX_LEVELS levels, so the
  // block is idle well before DRAIN_CYCLES have passed after its last result.
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned MAX_GAP       = 20;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PRINT_LIMIT   = 100;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 105;
  localparam int unsigned DIRECTED_ROWS = 27;

  // A phase level count of LEVELS_PICK means a random value over the full
  // register range, zero and the saturating values included.
  localparam int LEVELS_PICK = -1;
  localparam int PHASE_LEVELS [RANDOM_PHASES] = '{8, 1, 15, 0, LEVELS_PICK, 3,
                                                  LEVELS_PICK, 8, 2, LEVELS_PICK};

  typedef struct packed {
    status_e status;
    level_t  prio;
    slot_t   slot;
  } lock_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // Request mix of a random phase: balanced, piling up on one level until
  // its ring is full, or mostly releases that empty the rings again.
  typedef enum int {MODE_MIXED, MODE_FILL, MODE_DRAIN} mode_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             op;
    level_t           lvl;
    logic [CNT_W-1:0] levels;
    logic             typed;
    lock_result_t     res;
  } stim_row_t;

  // Directed requests. Rows with typed set carry a result that is obvious
  // from the rules; the others are checked against the predictor.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Release right after reset: nothing waits, so the resource stays free.
    '{ROW_ITEM, OP_RELEASE, 3'd0, 4'd0, 1'b1, '{ST_FREE,     3'd0, 6'd0}},
    // A request on a free resource is granted whatever its level.
    '{ROW_ITEM, OP_REQUEST, 3'd5, 4'd0, 1'b1, '{ST_GRANTED,  3'd0, 6'd0}},
    '{ROW_ITEM, OP_REQUEST, 3'd7, 4'd0, 1'b1, '{ST_QUEUED,   3'd7, 6'd0}},
    '{ROW_ITEM, OP_REQUEST, 3'd0, 4'd0, 1'b1, '{ST_QUEUED,   3'd0, 6'd0}},
    '{ROW_ITEM, OP_REQUEST, 3'd0, 4'd0, 1'b1, '{ST_QUEUED,   3'd0, 6'd1}},
    '{ROW_ITEM, OP_REQUEST, 3'd3, 4'd0, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}},
    // Releases serve level zero first, oldest ticket first, then the rest.
    '{ROW_ITEM, OP_RELEASE, 3'd0, 4'd0, 1'b1, '{ST_HANDED,   3'd0, 6'd0}},
    '{ROW_ITEM, OP_RELEASE, 3'd0, 4'd0, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}},
    '{ROW_ITEM, OP_RELEASE, 3'd0, 4'd0, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}},
    '{ROW_ITEM, OP_RELEASE, 3'd0, 4'd0, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}},
    '{ROW_ITEM, OP_RELEASE, 3'd0, 4'd0, 1'b1, '{ST_FREE,     3'd0, 6'd0}},
    // Release of a resource that is already free.
    '{ROW_ITEM, OP_RELEASE, 3'd0, 4'd0, 1'b1, '{ST_FREE,     3'd0, 6'd0}},
    '{ROW_ITEM, OP_REQUEST, 3'd7, 4'd0, 1'b1, '{ST_GRANTED,  3'd0, 6'd0}},
    '{ROW_ITEM, OP_REQUEST, 3'd2, 4'd0, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}},
    // Drop to two levels: level two is no longer accepted but keeps its
    // ticket, which is served again once the level comes back.
    '{ROW_CFG,  OP_REQUEST, 3'd0, 4'd2, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}},
    '{ROW_ITEM, OP_REQUEST, 3'd2, 4'd0, 1'b1, '{ST_REJECTED, 3'd0, 6'd0}},
    '{ROW_ITEM, OP_REQUEST, 3'd1, 4'd0, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}},
    '{ROW_ITEM, OP_RELEASE, 3'd0, 4'd0, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}},
    '{ROW_ITEM, OP_RELEASE, 3'd0, 4'd0, 1'b1, '{ST_FREE,     3'd0, 6'd0}},
    '{ROW_ITEM, OP_REQUEST, 3'd6, 4'd0, 1'b1, '{ST_GRANTED,  3'd0, 6'd0}},
    // A level count of zero acts as one level.
    '{ROW_CFG,  OP_REQUEST, 3'd0, 4'd0, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}},
    '{ROW_ITEM, OP_REQUEST, 3'd1, 4'd0, 1'b1, '{ST_REJECTED, 3'd0, 6'd0}},
    '{ROW_ITEM, OP_REQUEST, 3'd0, 4'd0, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}},
    // A level count of fifteen saturates to all levels.
    '{ROW_CFG,  OP_REQUEST, 3'd0, 4'd15, 1'b0, '{ST_GRANTED, 3'd0, 6'd0}},
    '{ROW_ITEM, OP_RELEASE, 3'd0, 4'd0, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}},
    '{ROW_ITEM, OP_RELEASE, 3'd0, 4'd0, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}},
    '{ROW_ITEM, OP_RELEASE, 3'd0, 4'd0, 1'b0, '{ST_GRANTED,  3'd0, 6'd0}}
  };

  // All inputs of the block hold known values from time zero.
  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                start              = 1'b0;
  logic                busy;
  logic                opcode_i           = OP_REQUEST;
  logic [LVL_W-1:0]    request_priority_i = '0;
  logic                cfg_valid_i        = 1'b0;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    cfg_wdata_i        = '0;
  logic                result_strobe_o;
  logic [STATUS_W-1:0] status_o;
  logic [LVL_W-1:0]    ticket_priority_o;
  logic [SLOT_W-1:0]   ticket_slot_o;

  // Predictor state: one ring per level, the lock flag and the level count.
  slot_t            ring_head [MAX_LEVELS];
  slot_t            ring_tail [MAX_LEVELS];
  logic             lock_held;
  logic [CNT_W-1:0] level_count;

  // Results still owed by the block, oldest first.
  lock_result_t pending_results [$];
  int unsigned  mismatches = 0;
  bit           gaps_on    = 1'b1;

  priority_fifo_lock_arbiter i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .request_priority_i(request_priority_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_wdata_i       (cfg_wdata_i),
    .result_strobe_o   (result_strobe_o),
    .status_o          (status_o),
    .ticket_priority_o (ticket_priority_o),
    .ticket_slot_o     (ticket_slot_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Every mismatch ends up here. Printing stops after PRINT_LIMIT lines so
  // that a badly broken block cannot flood the log, but counting goes on.
  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic slot_t slot_after(input slot_t s);
    return (s == slot_t'(RING_SLOTS - 1)) ? slot_t'(0) : s + slot_t'(1);
  endfunction

  // Works out the result of one lock operation and advances the predictor.
  function automatic lock_result_t lock_predict(input logic op, input level_t lvl);
    lock_result_t res;
    int unsigned  levels;
    bit           found;
    res.status = ST_FREE;
    res.prio   = '0;
    res.slot   = '0;
    found      = 1'b0;
    // The level count saturates to 1..MAX_LEVELS.
    if (level_count < 1) begin
      levels = 1;
    end else if (level_count > MAX_LEVELS) begin
      levels = MAX_LEVELS;
    end else begin
      levels = level_count;
    end
    if (op == OP_REQUEST) begin
      if (!lock_held) begin
        lock_held  = 1'b1;
        res.status = ST_GRANTED;
      end else if (lvl >= levels) begin
        res.status = ST_REJECTED;
      end else if (slot_after(ring_tail[lvl]) == ring_head[lvl]) begin
        // One slot of each ring stays unused, so this ring is full.
        res.status = ST_REJECTED;
      end else begin
        res.status     = ST_QUEUED;
        res.prio       = lvl;
        res.slot       = ring_tail[lvl];
        ring_tail[lvl] = slot_after(ring_tail[lvl]);
      end
    end else begin
      for (int unsigned i = 0; i < levels; i++) begin
        if (!found && ring_head[i] != ring_tail[i]) begin
          found        = 1'b1;
          res.status   = ST_HANDED;
          res.prio     = level_t'(i);
          res.slot     = ring_head[i];
          ring_head[i] = slot_after(ring_head[i]);
        end
      end
      // A waiter takes the lock over; with none the resource becomes free.
      lock_held = found;
    end
    return res;
  endfunction

  // Presents one lock operation, with a random gap before it, and holds it
  // until the block takes it. The task returns in the step of the accepting
  // edge and leaves start high, so that the next request or the next idle
  // cycle is the only assignment to start in that step.
  task automatic issue_lock_op(input logic op, input level_t lvl,
                               input logic typed, input lock_result_t typed_res);
    int unsigned  gap;
    lock_result_t res;
    gap = 0;
    while (gaps_on && gap < MAX_GAP && $urandom_range(99) < 36) begin
      start              <= 1'b0;
      opcode_i           <= 1'($urandom);
      request_priority_i <= level_t'($urandom);
      @(posedge clk_i);
      gap++;
    end
    start              <= 1'b1;
    opcode_i           <= op;
    request_priority_i <= lvl;
    do @(posedge clk_i); while (busy);
    res = lock_predict(op, lvl);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // Writes the level count once the block has delivered every result and
  // has had time to settle. The channel is always ready, but the handshake
  // is still waited for.
  task automatic write_level_count(input logic [CNT_W-1:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    level_count = value;
  endtask

  // Result checker. A strobe is taken at the edge that ends its cycle and
  // is compared with the oldest expected result.
  always @(posedge clk_i) begin : result_check
    lock_result_t due;
    if (rst_ni && result_strobe_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d level %0d slot %0d",
                                  status_o, ticket_priority_o, ticket_slot_o));
      end else begin
        due = pending_results.pop_front();
        if (status_o !== due.status || ticket_priority_o !== due.prio ||
            ticket_slot_o !== due.slot) begin
          report_mismatch($sformatf(
            "got status %0d level %0d slot %0d, wanted status %0d level %0d slot %0d",
            status_o, ticket_priority_o, ticket_slot_o,
            due.status, due.prio, due.slot));
        end
      end
    end
  end

  // Watchdog: the run is stuck once the quiet counter reaches QUIET_LIMIT;
  // an accepted request or write or a result clears the counter.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[priority_fifo_lock_arbiter] ERROR");
    $finish;
  end

  initial begin : stimulus
    int               pick;
    int unsigned      roll;
    int unsigned      active;
    int unsigned      waited;
    mode_e            mode;
    level_t           fill_lvl;
    logic             op;
    level_t           lvl;
    logic [CNT_W-1:0] levels_value;
    for (int unsigned i = 0; i < MAX_LEVELS; i++) begin
      ring_head[i] = '0;
      ring_tail[i] = '0;
    end
    lock_held   = 1'b0;
    level_count = LEVELS_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset level count until its first write.
    for (int unsigned r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_level_count(DIRECTED[r].levels);
      end else begin
        issue_lock_op(DIRECTED[r].op, DIRECTED[r].lvl, DIRECTED[r].typed,
                      DIRECTED[r].res);
      end
    end

    // Random part: each phase sets a level count and a request mix. Two
    // phases in the middle run back to back with no gaps at all.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      pick = PHASE_LEVELS[p];
      if (pick == LEVELS_PICK) begin
        pick = $urandom_range(15);
      end
      levels_value = pick[CNT_W-1:0];
      write_level_count(levels_value);
      active  = (pick < 1) ? 1 : (pick > MAX_LEVELS) ? MAX_LEVELS : pick;
      mode    = mode_e'(p % 3);
      gaps_on = !(p == 4 || p == 5);
      // A fill phase mostly targets a scanned level, so that its ring
      // really fills up and wraps, and now and then any level at all.
      if ($urandom_range(99) < 80) begin
        fill_lvl = level_t'($urandom_range(active - 1));
      end else begin
        fill_lvl = level_t'($urandom_range(MAX_LEVELS - 1));
      end
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(99);
        lvl  = level_t'($urandom_range(MAX_LEVELS - 1));
        case (mode)
          MODE_FILL: begin
            op = (roll < 88) ? OP_REQUEST : OP_RELEASE;
            if (roll < 80) begin
              lvl = fill_lvl;
            end
          end
          MODE_DRAIN: begin
            op = (roll < 30) ? OP_REQUEST : OP_RELEASE;
          end
          default: begin
            op = (roll < 50) ? OP_REQUEST : OP_RELEASE;
          end
        endcase
        issue_lock_op(op, lvl, 1'b0, '0);
      end
    end

    // Wait for the last results, then a little longer for stray strobes.
    start  <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < QUIET_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
    end

    if (mismatches == 0) begin
      $display("[priority_fifo_lock_arbiter] OK");
    end else begin
      $display("[priority_fifo_lock_arbiter] ERROR");
    end
    $finish;
  end

endmodule
